// ===== hw/rtl/tti_pkg.sv =====
// Shared constants, types and helper functions for the trajectory time interpolator.
// No dependencies; every other file in hw/rtl imports this package.
package tti_pkg;

    localparam int HISTORY_DEPTH   = 64;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int PTR_W           = $clog2(HISTORY_DEPTH);
    localparam int CNT_W           = $clog2(HISTORY_DEPTH + 1);
    localparam int TIME_W          = 63;
    localparam int POS_W           = 32;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_EMPTY = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]       tstamp;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_entry;

    typedef struct packed {
        logic                    status;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PREP,
        S_DIV,
        S_BLEND,
        S_BWAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    // Physical slot of logical entry k, counted from the oldest entry.
    function automatic logic [PTR_W-1:0] f_slot(input logic [PTR_W-1:0] oldest,
                                                 input logic [CNT_W-1:0] k);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(oldest) + (CNT_W + 1)'(k);
        if (sum >= (CNT_W + 1)'(HISTORY_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(HISTORY_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/tti_req_if.sv =====
// Request channel (push or query transaction) with valid/ready handshake.
// Depends on tti_pkg for field widths.
interface tti_req_if import tti_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [TIME_W-1:0]       time_stamp;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    modport source (output valid, action, time_stamp, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, action, time_stamp, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== hw/rtl/tti_rsp_if.sv =====
// Response channel (query result transaction) with valid/ready handshake.
// Depends on tti_pkg for field widths.
interface tti_rsp_if import tti_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    status;
    logic signed [POS_W-1:0] view_x;
    logic signed [POS_W-1:0] view_y;
    logic signed [POS_W-1:0] view_z;

    modport source (output valid, status, view_x, view_y, view_z, input ready);
    modport sink   (input valid, status, view_x, view_y, view_z, output ready);
endinterface

// ===== hw/rtl/tti_div.sv =====
// Restoring fractional divider: floor(num * 2^F / den), one quotient bit per cycle.
// Depends on tti_pkg; requires num < den.
module tti_div import tti_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [TIME_W-1:0]          i_num,
    input  logic [TIME_W-1:0]          i_den,
    output logic                       o_done,
    output logic [RATIO_FRAC_BITS-1:0] o_quo
);
    localparam int CW = $clog2(RATIO_FRAC_BITS + 1);

    logic [TIME_W-1:0]          r_rem;
    logic [TIME_W-1:0]          r_den;
    logic [RATIO_FRAC_BITS-1:0] r_quo;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [TIME_W:0] sh;
    logic [TIME_W:0] diff;
    logic            ge;

    always_comb begin
        sh   = {r_rem, 1'b0};
        ge   = (sh >= {1'b0, r_den});
        diff = sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RATIO_FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
            r_quo <= {r_quo[RATIO_FRAC_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== hw/rtl/tti_blend.sv =====
// Shared blend unit: (cur * 2^F + (past - cur) * r + 2^(F-1)) >> F, one coordinate per start.
// Three-stage pipeline (difference, multiply, round); depends on tti_pkg.
module tti_blend import tti_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [POS_W-1:0]    i_cur,
    input  logic signed [POS_W-1:0]    i_past,
    input  logic [RATIO_FRAC_BITS-1:0] i_ratio,
    output logic                       o_done,
    output logic signed [POS_W-1:0]    o_value
);
    localparam int PROD_W = POS_W + 1 + RATIO_FRAC_BITS + 1;
    localparam int SUM_W  = PROD_W + 1;

    logic                       r_v1, r_v2, r_v3;
    logic signed [POS_W:0]      r_d;
    logic [POS_W-1:0]           r_c1, r_c2;
    logic [RATIO_FRAC_BITS-1:0] r_r;
    logic signed [PROD_W-1:0]   r_p;
    logic [POS_W-1:0]           r_val;

    logic [SUM_W-1:0] cur_sh;
    logic [SUM_W-1:0] prod_ext;
    logic [SUM_W-1:0] sum;

    always_comb begin
        cur_sh   = {{(SUM_W - POS_W - RATIO_FRAC_BITS){r_c2[POS_W-1]}}, r_c2,
                    {RATIO_FRAC_BITS{1'b0}}};
        prod_ext = {{(SUM_W - PROD_W){r_p[PROD_W-1]}}, r_p};
        sum      = cur_sh + prod_ext + (SUM_W'(1) << (RATIO_FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d   <= $signed({i_past[POS_W-1], i_past}) - $signed({i_cur[POS_W-1], i_cur});
        r_c1  <= i_cur;
        r_r   <= i_ratio;
        r_p   <= PROD_W'(r_d) * PROD_W'($signed({1'b0, r_r}));
        r_c2  <= r_c1;
        r_val <= sum[RATIO_FRAC_BITS +: POS_W];
    end

    assign o_done  = r_v3;
    assign o_value = $signed(r_val);
endmodule

// ===== hw/rtl/trajectory_time_interpolator_core.sv =====
// Trajectory time interpolator top level: history memory, query sequencer, output register.
// Depends on tti_pkg, tti_req_if, tti_rsp_if, tti_div and tti_blend.
//
// Usage:
//   i_req carries push (action 0) and query (action 1) transactions. A push stores
//   time_stamp and pos_x/y/z in a 64-entry circular history, overwriting the oldest
//   entry when full; it produces no response and completes in the cycle it is taken.
//   A query produces exactly one o_rsp transaction with status and view_x/y/z.
//   A query walks the history at one entry per cycle, set by the single memory read
//   port; an interpolated result then passes a prep state, the bit-serial divider and
//   three passes of the shared blend multiplier, one per axis, into the output register.
//   An empty history goes straight to the output register; an end entry is returned
//   from the walk. The next request can be taken once the result has entered the
//   output register, so one query at a time occupies the block.
//   i_req.ready is high only while the sequencer idles; one query is in flight at a
//   time. A finished result sits in the output register while the next request is
//   taken; if the receiver stalls and a second result is ready, the sequencer holds.
//   Reset (synchronous, active low) empties the history and drops any pending
//   result; memory contents are left as they are and are never read before written.
module trajectory_time_interpolator_core import tti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tti_req_if.sink    i_req,
    tti_rsp_if.source  o_rsp
);
    // History memory: one read port (registered), one write port.
    t_entry mem [HISTORY_DEPTH];
    t_entry r_rd;

    // Sequencer state.
    t_state            r_state,  n_state;
    logic [PTR_W-1:0]  r_oldest, n_oldest;
    logic [CNT_W-1:0]  r_fill,   n_fill;
    logic [CNT_W-1:0]  r_k,      n_k;
    logic [TIME_W-1:0] r_q,      n_q;
    t_entry            r_cur,    n_cur;
    t_entry            r_prev,   n_prev;
    logic [RATIO_FRAC_BITS-1:0] r_ratio, n_ratio;
    t_axis             r_axis,   n_axis;
    t_result           r_res,    n_res;
    t_result           r_out,    n_out;
    logic              r_out_valid, n_out_valid;

    // Memory access and unit handshakes.
    logic              req_ok;
    logic              mem_we;
    logic [PTR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]  rd_addr;
    t_entry            wr_data;
    logic              more;

    logic                       div_start;
    logic [TIME_W-1:0]          div_num;
    logic [TIME_W-1:0]          div_den;
    logic                       div_done;
    logic [RATIO_FRAC_BITS-1:0] div_quo;

    logic                    blend_start;
    logic signed [POS_W-1:0] blend_cur;
    logic signed [POS_W-1:0] blend_past;
    logic                    blend_done;
    logic signed [POS_W-1:0] blend_val;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_ok      = i_req.valid && i_req.ready;

    assign wr_data.tstamp = i_req.time_stamp;
    assign wr_data.x      = i_req.pos_x;
    assign wr_data.y      = i_req.pos_y;
    assign wr_data.z      = i_req.pos_z;

    // Walk continues while a newer entry exists and the query lies after this one.
    assign more = ((CNT_W + 1)'(r_k) + (CNT_W + 1)'(1) < (CNT_W + 1)'(r_fill))
                  && (r_q > r_rd.tstamp);

    // Pick the coordinate pair for the blend unit.
    always_comb begin
        case (r_axis)
            AXIS_X: begin
                blend_cur  = r_cur.x;
                blend_past = r_prev.x;
            end
            AXIS_Y: begin
                blend_cur  = r_cur.y;
                blend_past = r_prev.y;
            end
            AXIS_Z: begin
                blend_cur  = r_cur.z;
                blend_past = r_prev.z;
            end
            default: begin
                blend_cur  = r_cur.x;
                blend_past = r_prev.x;
            end
        endcase
    end

    assign div_num = r_cur.tstamp - r_q;
    assign div_den = r_cur.tstamp - r_prev.tstamp;

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_fill      = r_fill;
        n_k         = r_k;
        n_q         = r_q;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_ratio     = r_ratio;
        n_axis      = r_axis;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        mem_we      = 1'b0;
        wr_addr     = r_oldest;
        rd_addr     = r_oldest;
        div_start   = 1'b0;
        blend_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Read address sits on the oldest slot so a query sees entry 0 next.
                if (req_ok) begin
                    if (i_req.action == ACT_PUSH) begin
                        mem_we = 1'b1;
                        if (r_fill < CNT_W'(HISTORY_DEPTH)) begin
                            wr_addr = f_slot(r_oldest, r_fill);
                            n_fill  = r_fill + CNT_W'(1);
                        end else begin
                            wr_addr  = r_oldest;
                            n_oldest = (r_oldest == PTR_W'(HISTORY_DEPTH - 1)) ?
                                       '0 : r_oldest + PTR_W'(1);
                        end
                    end else begin
                        n_q = i_req.time_stamp;
                        n_k = '0;
                        if (r_fill == '0) begin
                            n_res   = '0;
                            n_res.status = STAT_EMPTY;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                // Prefetch the next entry while comparing the current one.
                rd_addr = f_slot(r_oldest, r_k + CNT_W'(1));
                if (more) begin
                    n_prev = r_rd;
                    n_k    = r_k + CNT_W'(1);
                end else if (r_k == '0 || r_q > r_rd.tstamp) begin
                    n_res.status = STAT_OK;
                    n_res.x      = r_rd.x;
                    n_res.y      = r_rd.y;
                    n_res.z      = r_rd.z;
                    n_state      = S_OUT;
                end else begin
                    n_cur   = r_rd;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_ratio = div_quo;
                    n_axis  = AXIS_X;
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                blend_start = 1'b1;
                n_state     = S_BWAIT;
            end
            S_BWAIT: begin
                if (blend_done) begin
                    n_res.status = STAT_OK;
                    case (r_axis)
                        AXIS_X: begin
                            n_res.x = blend_val;
                            n_axis  = AXIS_Y;
                            n_state = S_BLEND;
                        end
                        AXIS_Y: begin
                            n_res.y = blend_val;
                            n_axis  = AXIS_Z;
                            n_state = S_BLEND;
                        end
                        default: begin
                            n_res.z = blend_val;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                // Hold until the output register is free or drains this cycle.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_axis      <= AXIS_X;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_axis      <= n_axis;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_q     <= n_q;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_ratio <= n_ratio;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // History memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    tti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    tti_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (blend_start),
        .i_cur   (blend_cur),
        .i_past  (blend_past),
        .i_ratio (r_ratio),
        .o_done  (blend_done),
        .o_value (blend_val)
    );

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out.status;
    assign o_rsp.view_x = r_out.x;
    assign o_rsp.view_y = r_out.y;
    assign o_rsp.view_z = r_out.z;
endmodule

// ===== tb/sv/tti_position_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the trajectory time interpolator: mirrors the position history,
// predicts each query answer and compares it with every response transaction.
// Depends on tti_pkg, tti_req_if and tti_rsp_if.
module tti_position_checker import tti_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tti_req_if   i_req,
    tti_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_queries,
    output int   o_interp,
    output int   o_clamped,
    output int   o_empty
);

    typedef enum logic [1:0] {
        ANS_EMPTY,
        ANS_END,
        ANS_BLEND
    } t_answer;

    logic [TIME_W-1:0]       hist_stamp [HISTORY_DEPTH];
    logic signed [POS_W-1:0] hist_px    [HISTORY_DEPTH];
    logic signed [POS_W-1:0] hist_py    [HISTORY_DEPTH];
    logic signed [POS_W-1:0] hist_pz    [HISTORY_DEPTH];
    int                      head_slot    = 0;
    int                      stored_count = 0;
    int                      n_results    = 0;
    t_result                 expected_positions [$];

    function automatic int slot_at(input int k);
        return (head_slot + k) % HISTORY_DEPTH;
    endfunction

    // Offset-binary blend, rounded half up: cur weighted by 1 - r, past by r.
    function automatic logic [POS_W-1:0] weigh_axis(input logic [POS_W-1:0] cur,
                                                    input logic [POS_W-1:0] past,
                                                    input logic [RATIO_FRAC_BITS:0] ratio);
        logic [63:0] uc;
        logic [63:0] up;
        logic [63:0] acc;
        uc  = {32'd0, ~cur[POS_W-1], cur[POS_W-2:0]};
        up  = {32'd0, ~past[POS_W-1], past[POS_W-2:0]};
        acc = uc * ((64'd1 << RATIO_FRAC_BITS) - 64'(ratio)) + up * 64'(ratio)
            + (64'd1 << (RATIO_FRAC_BITS - 1));
        acc = acc >> RATIO_FRAC_BITS;
        return {~acc[POS_W-1], acc[POS_W-2:0]};
    endfunction

    task automatic store_sample(input logic [TIME_W-1:0] ts, input logic [POS_W-1:0] x,
                                input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
        int w;
        if (stored_count < HISTORY_DEPTH) begin
            w = slot_at(stored_count);
            stored_count++;
        end else begin
            w = head_slot;
            head_slot = (head_slot + 1) % HISTORY_DEPTH;
        end
        hist_stamp[w] = ts;
        hist_px[w]    = x;
        hist_py[w]    = y;
        hist_pz[w]    = z;
    endtask

    task automatic predict_position(input logic [TIME_W-1:0] q, output t_result res,
                                    output t_answer kind);
        int                       k;
        int                       s;
        int                       p;
        int                       i;
        logic [63:0]              rem;
        logic [63:0]              den;
        logic [RATIO_FRAC_BITS:0] ratio;
        res = '0;
        if (stored_count == 0) begin
            res.status = STAT_EMPTY;
            kind = ANS_EMPTY;
        end else begin
            k = 0;
            s = slot_at(0);
            while (k + 1 < stored_count && q > hist_stamp[s]) begin
                k++;
                s = slot_at(k);
            end
            res.status = STAT_OK;
            if (k == 0 || q > hist_stamp[s]) begin
                res.x = hist_px[s];
                res.y = hist_py[s];
                res.z = hist_pz[s];
                kind = ANS_END;
            end else begin
                p     = slot_at(k - 1);
                rem   = 64'(hist_stamp[s] - q);
                den   = 64'(hist_stamp[s] - hist_stamp[p]);
                ratio = '0;
                for (i = 0; i < RATIO_FRAC_BITS; i++) begin
                    rem   = rem << 1;
                    ratio = ratio << 1;
                    if (rem >= den) begin
                        rem = rem - den;
                        ratio[0] = 1'b1;
                    end
                end
                res.x = weigh_axis(hist_px[s], hist_px[p], ratio);
                res.y = weigh_axis(hist_py[s], hist_py[p], ratio);
                res.z = weigh_axis(hist_pz[s], hist_pz[p], ratio);
                kind = ANS_BLEND;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic check_axis(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("response %0d %s: got %0d, expected %0d",
                                      n_results, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_answer kind;
        if (!i_rst_n) begin
            head_slot    = 0;
            stored_count = 0;
            expected_positions.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                if (i_req.action == ACT_PUSH) begin
                    store_sample(i_req.time_stamp, i_req.pos_x, i_req.pos_y, i_req.pos_z);
                end else begin
                    predict_position(i_req.time_stamp, want, kind);
                    expected_positions = {expected_positions, want};
                    o_queries++;
                    case (kind)
                        ANS_EMPTY: o_empty++;
                        ANS_END:   o_clamped++;
                        default:   o_interp++;
                    endcase
                end
            end
            if (i_rsp.valid && i_rsp.ready) begin
                n_results++;
                if (expected_positions.size() == 0) begin
                    report_mismatch($sformatf("response %0d with no query outstanding",
                                              n_results));
                end else begin
                    want = expected_positions.pop_front();
                    check_axis("status", int'(i_rsp.status), int'(want.status));
                    check_axis("view_x", int'(i_rsp.view_x), int'(want.x));
                    check_axis("view_y", int'(i_rsp.view_y), int'(want.y));
                    check_axis("view_z", int'(i_rsp.view_z), int'(want.z));
                end
            end
        end
        o_pending = expected_positions.size();
    end

endmodule

// ===== tb/sv/tb_trajectory_time_interpolator_core.sv =====
`timescale 1ns / 100ps
// Testbench top for trajectory_time_interpolator_core: clock, reset, push/query stimulus,
// response back-pressure, watchdog and verdict. Depends on tti_pkg, tti_req_if,
// tti_rsp_if, the core and tti_position_checker.
module tb_trajectory_time_interpolator_core import tti_pkg::*;
();

    localparam int RANDOM_ITEMS      = 800;
    localparam int HOLD_AT_ITEM      = 250;   // receiver starts its long hold-off here
    localparam int DRAIN_AT_ITEM     = 450;   // sender pauses for a full drain here
    localparam int BURST_FIRST_ITEM  = 520;   // window with no idling on either side
    localparam int BURST_LAST_ITEM   = 620;
    localparam int RSP_HOLD_CYCLES   = 600;
    localparam int DRAIN_TAIL_CYCLES = 150;   // a bit over the worst query latency
    localparam int WATCHDOG_LIMIT    = 4000;

    localparam logic [TIME_W-1:0]       TIME_LAST = '1;
    localparam logic signed [POS_W-1:0] COORD_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] COORD_MAX = {1'b0, {(POS_W-1){1'b1}}};

    logic clk;
    logic rst_n;

    tti_req_if req_ch ();
    tti_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int n_queries;
    int n_interp;
    int n_clamped;
    int n_empty;
    int n_pushes = 0;

    // Flags shared between the sender and receiver processes.
    bit idle_on  = 1'b1;
    bit hold_rsp = 1'b0;

    // Times of recent pushes, in push order; used only to aim queries.
    logic [TIME_W-1:0] recent_stamps [$];
    logic [TIME_W-1:0] stamp_cursor;

    trajectory_time_interpolator_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tti_position_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_queries    (n_queries),
        .o_interp     (n_interp),
        .o_clamped    (n_clamped),
        .o_empty      (n_empty)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle length: mostly none or short, a few long.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TIME_W-1:0] rand_stamp();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic signed [POS_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Aim a query at the interesting spots of the recent history: inside a
    // bracket, on a stored time, just around one, past either end, or anywhere.
    function automatic logic [TIME_W-1:0] pick_query_time();
        int                n;
        int                i;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] span;
        n = recent_stamps.size();
        if (n == 0) begin
            return rand_stamp();
        end
        i  = $urandom_range(0, n - 1);
        lo = recent_stamps[i];
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                if (i + 1 < n && recent_stamps[i + 1] > lo) begin
                    span = recent_stamps[i + 1] - lo;
                    return lo + 1 + (rand_stamp() % span);
                end
                return lo;
            end
            3:       return lo;
            4:       return lo - TIME_W'($urandom_range(0, 3)) + TIME_W'($urandom_range(0, 3));
            5:       return recent_stamps[0] - TIME_W'($urandom_range(0, 1000));
            6:       return recent_stamps[n - 1] + TIME_W'($urandom_range(1, 1000000));
            7:       return TIME_LAST;
            8:       return '0;
            default: return rand_stamp();
        endcase
    endfunction

    // Offer one request transaction. Enter and leave at a falling edge; the
    // caller either drives the next item or drops valid at the edge we return on.
    task automatic offer_item(input logic act, input logic [TIME_W-1:0] ts,
                              input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y,
                              input logic signed [POS_W-1:0] z);
        int gap;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.time_stamp <= ts;
        req_ch.pos_x      <= x;
        req_ch.pos_y      <= y;
        req_ch.pos_z      <= z;
        // Hold the item until a rising edge sees ready high.
        do @(posedge clk); while (!req_ch.ready);
        if (act == ACT_PUSH) begin
            n_pushes++;
            recent_stamps = {recent_stamps, ts};
            if (recent_stamps.size() > HISTORY_DEPTH) begin
                void'(recent_stamps.pop_front());
            end
        end
        @(negedge clk);
    endtask

    // Response side: random stalls, a stall-free window, and one long hold-off
    // counted here so the core fills up while the sender keeps offering.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
                rsp_ch.ready <= 1'b1;
            end else if (!idle_on) begin
                rsp_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                rsp_ch.ready <= (stall_left == 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Watchdog: no transaction for %0d cycles, %0d responses outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int   item_no;
        int   seg_len;
        int   j;
        int   kind;
        bit   hold_armed;
        bit   drained;
        hold_armed = 1'b0;
        drained    = 1'b0;

        // Drive every input to a known value before the first edge.
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_PUSH;
        req_ch.time_stamp = '0;
        req_ch.pos_x      = '0;
        req_ch.pos_y      = '0;
        req_ch.pos_z      = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Query the empty history at both time extremes first.
        offer_item(ACT_QUERY, '0, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, TIME_LAST, rand_coord(), rand_coord(), rand_coord());
        // Single entry: every query returns it.
        offer_item(ACT_PUSH, 63'd1000, COORD_MAX, COORD_MIN, '0);
        offer_item(ACT_QUERY, '0, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, 63'd1000, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, TIME_LAST, rand_coord(), rand_coord(), rand_coord());
        // Second entry at the opposite coordinate extremes: blend across full range.
        offer_item(ACT_PUSH, 63'd2000, COORD_MIN, COORD_MAX, '1);
        offer_item(ACT_QUERY, 63'd1500, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, 63'd1001, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, 63'd1999, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, 63'd2000, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, 63'd2001, rand_coord(), rand_coord(), rand_coord());
        // Out-of-order push: the walk rule alone decides the answer.
        offer_item(ACT_PUSH, 63'd500, 32'sd123456, -32'sd654321, 32'sd1);
        offer_item(ACT_QUERY, 63'd1200, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, 63'd600, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, 63'd2500, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, 63'd500, rand_coord(), rand_coord(), rand_coord());
        // Widest possible bracket: time zero next to the last representable time.
        offer_item(ACT_PUSH, '0, COORD_MIN, COORD_MIN, COORD_MAX);
        offer_item(ACT_PUSH, TIME_LAST, COORD_MAX, COORD_MAX, COORD_MIN);
        offer_item(ACT_QUERY, TIME_LAST - 1, rand_coord(), rand_coord(), rand_coord());
        offer_item(ACT_QUERY, {2'b01, {(TIME_W-2){1'b0}}}, rand_coord(), rand_coord(),
                   rand_coord());

        // Random part: mostly rising trajectories with queries aimed at the
        // history, some noise, and some repeated or backward timestamps.
        stamp_cursor = rand_stamp() >> $urandom_range(1, 62);
        item_no = 0;
        while (item_no < RANDOM_ITEMS) begin
            idle_on = !(item_no >= BURST_FIRST_ITEM && item_no < BURST_LAST_ITEM);
            if (!hold_armed && item_no >= HOLD_AT_ITEM) begin
                hold_armed = 1'b1;
                hold_rsp   = 1'b1;
            end
            if (!drained && item_no >= DRAIN_AT_ITEM) begin
                // Drop valid and let every outstanding response come back.
                drained = 1'b1;
                req_ch.valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end

            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                if ($urandom_range(0, 4) == 0) begin
                    stamp_cursor = rand_stamp() >> $urandom_range(0, 40);
                end
                seg_len = $urandom_range(4, 24);
                for (j = 0; j < seg_len; j++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        offer_item(ACT_QUERY, pick_query_time(), rand_coord(), rand_coord(),
                                   rand_coord());
                    end else begin
                        stamp_cursor = stamp_cursor + 1 + (rand_stamp() >> $urandom_range(20, 62));
                        offer_item(ACT_PUSH, stamp_cursor, rand_coord(), rand_coord(),
                                   rand_coord());
                    end
                end
                item_no += seg_len;
            end else if (kind <= 8) begin
                seg_len = $urandom_range(1, 6);
                for (j = 0; j < seg_len; j++) begin
                    offer_item(logic'($urandom_range(0, 1)), rand_stamp(), rand_coord(),
                               rand_coord(), rand_coord());
                end
                item_no += seg_len;
            end else begin
                // Duplicate stamps, then a step back, then a query among them.
                offer_item(ACT_PUSH, stamp_cursor, rand_coord(), rand_coord(), rand_coord());
                offer_item(ACT_PUSH, stamp_cursor, rand_coord(), rand_coord(), rand_coord());
                offer_item(ACT_PUSH, stamp_cursor - TIME_W'($urandom_range(1, 5000)),
                           rand_coord(), rand_coord(), rand_coord());
                offer_item(ACT_QUERY, stamp_cursor - TIME_W'($urandom_range(0, 5000)),
                           rand_coord(), rand_coord(), rand_coord());
                item_no += 4;
            end
        end
        req_ch.valid <= 1'b0;
        idle_on = 1'b1;

        // Wait out every response, then watch a while for stray ones.
        wait (pending == 0);
        repeat (DRAIN_TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d pushes and %0d queries: %0d interpolated, %0d held at an end, %0d on an empty history.",
                 n_pushes, n_queries, n_interp, n_clamped, n_empty);
        $display("Included a %0d-cycle response hold-off, a mid-run drain and a stall-free burst; %0d mismatches.",
                 RSP_HOLD_CYCLES, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
